FILE: hw/rtl/efd_pkg.sv
// Shared types and constants for the escaped frame decoder.
package efd_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // Checksum target: 0xFF minus the low byte of the payload sum
  localparam logic [7:0] ChecksumBase = 8'hFF;

  // Reset values of the configuration registers
  localparam logic [7:0] StartCodeReset  = 8'h7E;
  localparam logic [7:0] EscapeCodeReset = 8'h7D;
  localparam logic [7:0] EscapeXorReset  = 8'h20;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgStartCode  = 2'd0,
    CfgEscapeCode = 2'd1,
    CfgEscapeXor  = 2'd2
  } cfg_index_e;

  // Frame parser phases; codes 5 to 7 act as waiting
  typedef enum logic [2:0] {
    PhWait    = 3'd0,
    PhLenHi   = 3'd1,
    PhLenLo   = 3'd2,
    PhPayload = 3'd3,
    PhCheck   = 3'd4
  } phase_e;

  // Live configuration seen by the front
  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] escape_code;
    logic [7:0] escape_xor;
  } cfg_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic       is_check;  // 1: checksum byte, 0: payload byte
    logic [7:0] data;      // unescaped byte
  } q_item_t;

endpackage

FILE: hw/rtl/efd_front.sv
// Front end: frame parsing, unescaping and byte classification.
module efd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  efd_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  output logic             push_o,
  output efd_pkg::q_item_t push_item_o,
  input  logic             q_full_i
);
  import efd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;

  logic        accept;
  logic [7:0]  byte_dec;
  logic [15:0] len_full;
  logic [15:0] seen_inc;
  logic        in_frame;
  logic        is_esc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_frame   = (phase_q == PhLenHi) || (phase_q == PhLenLo) ||
                      (phase_q == PhPayload) || (phase_q == PhCheck);
  assign is_esc     = (in_byte_i == cfg_i.escape_code);
  assign byte_dec   = esc_q ? (in_byte_i ^ cfg_i.escape_xor) : in_byte_i;
  assign len_full   = {len_hi_q, byte_dec};
  assign seen_inc   = seen_q + 16'd1;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    seen_d   = seen_q;
    if (accept) begin
      if (!in_frame) begin
        esc_d   = 1'b0;
        phase_d = (in_byte_i == cfg_i.start_code) ? PhLenHi : PhWait;
      end else if (is_esc) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        case (phase_q)
          PhLenHi: begin
            len_hi_d = byte_dec;
            phase_d  = PhLenLo;
          end
          PhLenLo: begin
            len_d   = len_full;
            seen_d  = 16'd0;
            phase_d = (len_full == 16'd0) ? PhCheck : PhPayload;
          end
          PhPayload: begin
            seen_d = seen_inc;
            if (seen_inc == len_q) begin
              phase_d = PhCheck;
            end
          end
          default: begin
            phase_d = PhWait;
          end
        endcase
      end
    end
  end

  // Queue push for payload and checksum bytes
  always_comb begin
    push_o               = 1'b0;
    push_item_o.is_check = 1'b0;
    push_item_o.data     = byte_dec;
    if (accept && in_frame && !is_esc) begin
      case (phase_q)
        PhPayload: begin
          push_o = 1'b1;
        end
        PhCheck: begin
          push_o               = 1'b1;
          push_item_o.is_check = 1'b1;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWait;
      esc_q    <= 1'b0;
      len_hi_q <= 8'd0;
      len_q    <= 16'd0;
      seen_q   <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
    end
  end

`ifndef SYNTHESIS
  // A checksum byte always closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_item_o.is_check) |=> (phase_q == PhWait))
    else $error("front: phase not waiting after checksum byte");
`endif

endmodule

FILE: hw/rtl/efd_fifo.sv
// Small queue between the front and back of the decoder.
module efd_fifo #(
  parameter int unsigned Depth = efd_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  efd_pkg::q_item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output efd_pkg::q_item_t pop_item_o
);
  import efd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_item_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("fifo: push while full");
  // The back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("fifo: pop while empty");
`endif

endmodule

FILE: hw/rtl/efd_back.sv
// Back end: checksum accumulation and registered result output.
module efd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  efd_pkg::q_item_t q_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic             out_good_o
);
  import efd_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_good_q, out_good_d;
  logic [7:0] sum_q, sum_d;

  // Load the output register when it is empty or being drained
  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_good_d  = out_good_q;
    sum_d       = sum_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d = 1'b1;
      if (q_item_i.is_check) begin
        out_byte_d = 8'd0;
        out_last_d = 1'b1;
        out_good_d = (q_item_i.data == (ChecksumBase - sum_q));
        sum_d      = 8'd0;
      end else begin
        out_byte_d = q_item_i.data;
        out_last_d = 1'b0;
        out_good_d = 1'b0;
        sum_d      = sum_q + q_item_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sum_q       <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_good_q <= out_good_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_good_o  = out_good_q;

`ifndef SYNTHESIS
  // End items carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_byte_q == 8'd0))
    else $error("back: end item with nonzero byte");
  // The good flag only appears on end items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_good_q) |-> out_last_q)
    else $error("back: good flag on payload item");
  // The sum restarts after every end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_item_i.is_check) |=> (sum_q == 8'd0))
    else $error("back: running sum not cleared");
`endif

endmodule

FILE: hw/rtl/escaped_frame_decoder.sv
// Top level of the escaped frame decoder: config registers, front, queue, back.
//
//  Channel  | Dir | Handshake            | Payload
//  ---------+-----+----------------------+-------------------------------------
//  s_axis   | in  | tvalid / tready      | tdata[7:0] rx_byte
//  m_axis   | out | tvalid / tready      | tdata[7:0] byte_value, tlast
//           |     |                      | end_of_frame, tuser frame_good
//  cfg      | in  | cfg_valid / cfg_ready| cfg_index (0..2), cfg_data[7:0]
//
// One received byte is taken each cycle while the queue is not full; a result
// is registered in a queue entry, then in the output register.
// Back-pressure on m_axis fills the output register and then the queue of
// QueueDepth entries; s_axis_tready drops only when the queue is full.
// Reset puts the parser in the waiting phase and loads the default codes;
// no clearing pass is needed. cfg writes are always accepted.
module escaped_frame_decoder #(
  parameter int unsigned QueueDepth = efd_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_value
  output logic       m_axis_tlast_o,   // end_of_frame
  output logic       m_axis_tuser_o,   // [0] frame_good
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import efd_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    push;
  q_item_t push_item;
  logic    q_full;
  logic    pop;
  logic    q_valid;
  q_item_t q_item;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartCode:  cfg_d.start_code  = cfg_data_i;
        CfgEscapeCode: cfg_d.escape_code = cfg_data_i;
        CfgEscapeXor:  cfg_d.escape_xor  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code  <= StartCodeReset;
      cfg_q.escape_code <= EscapeCodeReset;
      cfg_q.escape_xor  <= EscapeXorReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  efd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .push_o      (push),
    .push_item_o (push_item),
    .q_full_i    (q_full)
  );

  efd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  efd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_good_o  (m_axis_tuser_o)
  );

endmodule

FILE: sim/tb_top.sv
// Testbench for the escaped frame decoder: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import efd_pkg::*;

  localparam int unsigned ClkPeriod    = 4;
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned LongHold     = 80;
  localparam int unsigned RandomBytes  = 600;
  localparam int unsigned MaxReports   = 10;
  localparam logic [1:0]  CfgIndexNone = 2'd3;  // index past the register list

  // One decoded output transaction
  typedef struct packed {
    logic [7:0] value;
    logic       eof;
    logic       good;
  } dec_result_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       s_valid   = 1'b0;
  logic [7:0] s_data    = 8'h00;
  logic       s_ready;
  logic       m_valid;
  logic       m_ready   = 1'b0;
  logic [7:0] m_data;
  logic       m_last;
  logic       m_user;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data  = 8'h00;

  // Decoder state as the testbench sees it
  logic [7:0]  cur_start = StartCodeReset;
  logic [7:0]  cur_esc   = EscapeCodeReset;
  logic [7:0]  cur_xor   = EscapeXorReset;
  phase_e      ph        = PhWait;
  logic        esc_pend  = 1'b0;
  logic [15:0] flen      = '0;
  logic [15:0] fseen     = '0;
  logic [7:0]  fsum      = '0;

  dec_result_t  decoded_q[$];
  int unsigned  mismatches  = 0;
  int unsigned  frame_bytes = 0;
  bit           quiet       = 1'b0;
  bit           hold_req    = 1'b0;

  escaped_frame_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .m_axis_tuser_o (m_user),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Append one expected result at the tail of the queue
  function automatic void add_expected(input dec_result_t r);
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  // Advance the frame parser by one received byte and queue what it emits
  function automatic void decode_rx_byte(input logic [7:0] raw);
    logic [7:0]  b;
    logic [7:0]  chk;
    dec_result_t r;
    b = raw;
    if (ph == PhWait) begin
      esc_pend = 1'b0;
      if (b == cur_start) ph = PhLenHi;
      return;
    end
    frame_bytes++;
    if (b == cur_esc) begin
      esc_pend = 1'b1;
      return;
    end
    if (esc_pend) begin
      b        = b ^ cur_xor;
      esc_pend = 1'b0;
    end
    case (ph)
      PhLenHi: begin
        flen = {b, 8'h00};
        ph   = PhLenLo;
      end
      PhLenLo: begin
        flen[7:0] = b;
        fseen     = '0;
        fsum      = '0;
        ph        = (flen == 16'd0) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        fsum  = fsum + b;
        fseen = fseen + 16'd1;
        if (fseen == flen) ph = PhCheck;
        r.value = b;
        r.eof   = 1'b0;
        r.good  = 1'b0;
        add_expected(r);
      end
      default: begin
        chk      = ChecksumBase - fsum;
        r.value  = 8'h00;
        r.eof    = 1'b1;
        r.good   = (b == chk);
        add_expected(r);
        ph       = PhWait;
        esc_pend = 1'b0;
      end
    endcase
  endfunction

  // One received byte; valid stays high afterwards until the next call or a drain
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    decode_rx_byte(b);
  endtask

  // Byte inside a frame, escaped when needed and sometimes at random
  task automatic send_coded(input logic [7:0] b);
    if ((b == cur_esc || $urandom_range(0, 9) == 0) && ((b ^ cur_xor) != cur_esc)) begin
      send_byte(cur_esc);
      if ($urandom_range(0, 7) == 0) send_byte(cur_esc);
      send_byte(b ^ cur_xor);
    end else begin
      send_byte(b);
    end
  endtask

  // Payload byte that can be carried under the current codes
  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0:       b = cur_start;
      1:       b = cur_esc;
      2:       b = 8'h00;
      3:       b = 8'hFF;
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (cur_xor == 8'h00 && b == cur_esc) b = b ^ 8'h01;
    return b;
  endfunction

  // Full frame; payload_cnt bounds how much payload goes out before giving up
  task automatic send_frame(input int unsigned len, input bit bad_cs,
                            input int unsigned payload_cnt);
    logic [15:0] l;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  cs;
    l   = 16'(len);
    sum = 8'h00;
    if (cur_xor == 8'h00 && l[7:0] == cur_esc) l[7:0] = l[7:0] ^ 8'h01;
    send_byte(cur_start);
    send_coded(l[15:8]);
    send_coded(l[7:0]);
    for (int unsigned i = 0; i < l && i < payload_cnt; i++) begin
      b   = pick_payload();
      sum = sum + b;
      send_coded(b);
    end
    if (payload_cnt < l) return;
    cs = ChecksumBase - sum;
    if (bad_cs) cs = cs ^ (8'h01 << $urandom_range(0, 7));
    send_coded(cs);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return 0;
    if (r < 16) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  // Let the parser run back to waiting with random bytes
  task automatic flush_frame();
    while (ph != PhWait) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait until every expected result is out
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write transaction; valid is dropped by the caller
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CfgStartCode:  cur_start = val;
      CfgEscapeCode: cur_esc   = val;
      CfgEscapeXor:  cur_xor   = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] st, input logic [7:0] es, input logic [7:0] xm);
    wait_drained();
    write_reg(CfgStartCode, st);
    write_reg(CfgEscapeCode, es);
    write_reg(CfgEscapeXor, xm);
    cfg_valid <= 1'b0;
  endtask

  // One random item: mostly clean frames, some damaged ones and line noise
  task automatic send_random_item();
    int unsigned r;
    int unsigned len;
    r   = $urandom_range(0, 99);
    len = pick_len();
    if (r < 72) begin
      send_frame(len, 1'b0, len);
    end else if (r < 84) begin
      send_frame(len, 1'b1, len);
    end else if (r < 92) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_frame(len + 2, 1'b0, $urandom_range(0, len + 1));
    end
    flush_frame();
  endtask

  // Reset codes: noise while waiting, escapes, start code as data, empty frame, double escape, wrong checksum
  task automatic test_reset_codes();
    send_byte(8'h00);
    send_byte(cur_esc);
    send_byte(8'hFF);
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'hFF);
    send_byte(cur_esc);
    send_byte(cur_start ^ cur_xor);
    send_byte(8'h00);
    send_byte(ChecksumBase - (8'hFF + cur_start));
    // empty frame goes straight to its checksum
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(ChecksumBase);
    // double escape, start code inside payload, wrong checksum
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(cur_esc);
    send_byte(cur_esc);
    send_byte(cur_esc ^ cur_xor);
    send_byte(cur_start);
    send_byte(8'h00);
  endtask

  // Extreme code settings, equal start and escape codes, ignored index
  task automatic test_code_extremes();
    set_codes(8'h00, 8'hFF, 8'hFF);
    repeat (4) send_frame(pick_len(), 1'b0, 1000);
    set_codes(8'hFF, 8'hFE, 8'h00);
    write_reg(CfgIndexNone, 8'h55);
    cfg_valid <= 1'b0;
    repeat (4) send_frame(pick_len(), 1'b0, 1000);
    set_codes(8'h42, 8'h42, 8'h01);
    repeat (3) send_frame(pick_len(), 1'b0, 1000);
    set_codes(StartCodeReset, EscapeCodeReset, EscapeXorReset);
  endtask

  // Receiver holds off long while a frame keeps coming
  task automatic test_output_hold();
    wait_drained();
    hold_req = 1'b1;
    send_frame(24, 1'b0, 24);
    send_frame(6, 1'b1, 6);
  endtask

  // Random items under several code settings, one long frame among them
  task automatic test_random_frames(input int unsigned goal);
    logic [7:0] es;
    logic [7:0] xm;
    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        es = 8'($urandom_range(0, 255));
        xm = 8'($urandom_range(0, 255));
        if (xm == 8'h00) es[7] = 1'b1;
        set_codes(8'($urandom_range(0, 255)), es, xm);
      end
      if (p == 1) send_frame(260, 1'b0, 260);
      while (frame_bytes < goal * (p + 1) / 5) send_random_item();
    end
  endtask

  // Last stretch with neither side idling
  task automatic test_full_rate(input int unsigned goal);
    set_codes(StartCodeReset, EscapeCodeReset, EscapeXorReset);
    quiet = 1'b1;
    while (frame_bytes < goal) send_random_item();
  endtask

  // Output ready: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest queued result
  always @(posedge clk_i) begin
    dec_result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected output: data %h last %b user %b",
                   $time, m_data, m_last, m_user);
      end else begin
        want = decoded_q.pop_front();
        if (m_data !== want.value || m_last !== want.eof || m_user !== want.good) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: mismatch: expected data %h last %b user %b, got %h %b %b",
                     $time, want.value, want.eof, want.good, m_data, m_last, m_user);
        end
      end
    end
  end

  // Test sequence
  initial begin
    int unsigned goal;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_codes();
    test_code_extremes();
    test_output_hold();
    goal = frame_bytes + RandomBytes;
    test_random_frames(goal);
    test_full_rate(goal);
    wait_drained();
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
